### sv/brbm_pkg.sv
// ----------------------------------------------------------------------------
// brbm_pkg
// Shared geometry, command and result types, and index helpers for the
// banked row buffer memory.
// ----------------------------------------------------------------------------
package brbm_pkg;

  localparam int BANKS     = 4;
  localparam int ROWS      = 256;
  localparam int COLUMNS   = 256;
  localparam int WORD_BITS = 16;

  localparam int BANK_W  = (BANKS > 1) ? $clog2(BANKS) : 1;
  localparam int ROW_W   = $clog2(ROWS);
  localparam int COL_W   = $clog2(COLUMNS);
  localparam int COL_CW  = $clog2(COLUMNS + 1);
  localparam int CELL_AW = BANK_W + ROW_W + COL_W;
  localparam int RB_AW   = BANK_W + COL_W;

  typedef logic [WORD_BITS-1:0] word_t;

  typedef enum logic [1:0] {
    KIND_ACTIVATE  = 2'd0,
    KIND_PRECHARGE = 2'd1,
    KIND_READ      = 2'd2,
    KIND_WRITE     = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ACT,
    ST_PRE,
    ST_READ
  } state_t;

  typedef struct packed {
    kind_t       kind;
    logic [1:0]  bank;
    logic [7:0]  row;
    logic [7:0]  column;
    logic [15:0] write_data;
  } cmd_t;

  typedef struct packed {
    logic [15:0] rd_word;
    kind_t       done_kind;
  } result_t;

  function automatic logic [BANK_W-1:0] bank_idx(input logic [1:0] b);
    logic [BANK_W+1:0] t;
    t = {{BANK_W{1'b0}}, b};
    return t[BANK_W-1:0];
  endfunction

  function automatic logic [ROW_W-1:0] row_idx(input logic [7:0] r);
    logic [ROW_W+7:0] t;
    t = {{ROW_W{1'b0}}, r};
    return t[ROW_W-1:0];
  endfunction

  function automatic logic [COL_W-1:0] col_idx(input logic [7:0] c);
    logic [COL_W+7:0] t;
    t = {{COL_W{1'b0}}, c};
    return t[COL_W-1:0];
  endfunction

  function automatic word_t to_word(input logic [15:0] d);
    logic [WORD_BITS+15:0] t;
    t = {{WORD_BITS{1'b0}}, d};
    return t[WORD_BITS-1:0];
  endfunction

  function automatic logic [15:0] from_word(input word_t w);
    logic [WORD_BITS+15:0] t;
    t = {16'h0000, w};
    return t[15:0];
  endfunction

endpackage

### sv/brbm_ram.sv
// ----------------------------------------------------------------------------
// brbm_ram
// Simple dual-port synchronous RAM: one write port, one read port with a
// registered read.
// ----------------------------------------------------------------------------
module brbm_ram #(
  parameter int AW = 8,
  parameter int DW = 16
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [1<<AW];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### sv/banked_row_buffer_memory.sv
// ----------------------------------------------------------------------------
// banked_row_buffer_memory
// Multi-bank word memory with one row buffer per bank.
// ----------------------------------------------------------------------------
// A command transaction is taken when start is high and busy is low, and each
// command returns exactly one result, shown for one cycle with out_valid high;
// the receiver cannot stall it. After reset the block is busy for a clearing
// pass over every cell address that zeroes the cell array and the row buffers
// one word a cycle. Write and rejected commands finish without raising busy,
// so they can be issued every cycle, with the result in the cycle after the
// transaction. A read holds busy in ST_READ while the registered row buffer
// read returns its word, and its result is registered from there. Activate
// and precharge copy a whole row, one word per cycle through the cell array
// and row buffer RAM ports, holding busy until the copy is done; their result
// follows right after.
module banked_row_buffer_memory (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  brbm_pkg::cmd_t    in_cmd,
  output logic              out_valid,
  output brbm_pkg::result_t out_result
);

  brbm_pkg::state_t state_r, state_nxt;

  logic [brbm_pkg::CELL_AW-1:0] clr_r, clr_nxt;
  logic [brbm_pkg::COL_CW-1:0]  cnt_r, cnt_nxt;
  logic [brbm_pkg::BANK_W-1:0]  bank_r;
  logic [brbm_pkg::ROW_W-1:0]   row_r;
  logic [brbm_pkg::COL_W-1:0]   wcol_r;
  logic                         rd_valid_r, rd_valid_nxt;
  logic [brbm_pkg::ROW_W-1:0]   open_row_r [brbm_pkg::BANKS];
  logic                         out_valid_r, out_valid_nxt;
  brbm_pkg::result_t            out_result_r, out_result_nxt;

  logic accept, bank_ok, row_ok, col_ok, copy_issue, copy_last, do_open;

  logic                         cell_we;
  logic [brbm_pkg::CELL_AW-1:0] cell_waddr, cell_raddr;
  brbm_pkg::word_t              cell_wdata, cell_rdata;
  logic                         rb_we;
  logic [brbm_pkg::RB_AW-1:0]   rb_waddr, rb_raddr;
  brbm_pkg::word_t              rb_wdata, rb_rdata;

  assign busy   = (state_r != brbm_pkg::ST_IDLE);
  assign accept = start && !busy;

  assign bank_ok = (32'(in_cmd.bank) < brbm_pkg::BANKS);
  assign row_ok  = (32'(in_cmd.row) < brbm_pkg::ROWS);
  assign col_ok  = (32'(in_cmd.column) < brbm_pkg::COLUMNS);

  assign copy_issue = (cnt_r < brbm_pkg::COL_CW'(brbm_pkg::COLUMNS));
  assign copy_last  = (cnt_r == brbm_pkg::COL_CW'(brbm_pkg::COLUMNS));
  assign do_open    = accept && (in_cmd.kind == brbm_pkg::KIND_ACTIVATE) && bank_ok && row_ok;

  brbm_ram #(.AW(brbm_pkg::CELL_AW), .DW(brbm_pkg::WORD_BITS)) u_cell (
    .clk   (clk),
    .we    (cell_we),
    .waddr (cell_waddr),
    .wdata (cell_wdata),
    .raddr (cell_raddr),
    .rdata (cell_rdata)
  );

  brbm_ram #(.AW(brbm_pkg::RB_AW), .DW(brbm_pkg::WORD_BITS)) u_rowbuf (
    .clk   (clk),
    .we    (rb_we),
    .waddr (rb_waddr),
    .wdata (rb_wdata),
    .raddr (rb_raddr),
    .rdata (rb_rdata)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      brbm_pkg::ST_CLEAR: begin
        if (clr_r == '1) begin
          state_nxt = brbm_pkg::ST_IDLE;
        end
      end
      brbm_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (in_cmd.kind)
            brbm_pkg::KIND_ACTIVATE: begin
              if (bank_ok && row_ok) state_nxt = brbm_pkg::ST_ACT;
            end
            brbm_pkg::KIND_PRECHARGE: begin
              if (bank_ok) state_nxt = brbm_pkg::ST_PRE;
            end
            brbm_pkg::KIND_READ: begin
              if (bank_ok && col_ok) state_nxt = brbm_pkg::ST_READ;
            end
            brbm_pkg::KIND_WRITE: begin
              state_nxt = brbm_pkg::ST_IDLE;
            end
          endcase
        end
      end
      brbm_pkg::ST_ACT, brbm_pkg::ST_PRE: begin
        if (copy_last) begin
          state_nxt = brbm_pkg::ST_IDLE;
        end
      end
      brbm_pkg::ST_READ: begin
        state_nxt = brbm_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = brbm_pkg::ST_CLEAR;
      end
    endcase
  end

  always_comb begin
    clr_nxt        = clr_r;
    cnt_nxt        = cnt_r;
    rd_valid_nxt   = 1'b0;
    out_valid_nxt  = 1'b0;
    out_result_nxt = out_result_r;
    cell_we        = 1'b0;
    cell_waddr     = '0;
    cell_wdata     = '0;
    cell_raddr     = {bank_r, row_r, cnt_r[brbm_pkg::COL_W-1:0]};
    rb_we          = 1'b0;
    rb_waddr       = '0;
    rb_wdata       = '0;
    rb_raddr       = {bank_r, cnt_r[brbm_pkg::COL_W-1:0]};
    unique case (state_r)
      brbm_pkg::ST_CLEAR: begin
        clr_nxt  = clr_r + 1'b1;
        cell_we  = 1'b1;
        cell_waddr = clr_r;
        rb_we    = 1'b1;
        rb_waddr = clr_r[brbm_pkg::RB_AW-1:0];
      end
      brbm_pkg::ST_IDLE: begin
        cnt_nxt  = '0;
        rb_raddr = {brbm_pkg::bank_idx(in_cmd.bank), brbm_pkg::col_idx(in_cmd.column)};
        rb_waddr = rb_raddr;
        rb_wdata = brbm_pkg::to_word(in_cmd.write_data);
        if (accept) begin
          rb_we = (in_cmd.kind == brbm_pkg::KIND_WRITE) && bank_ok && col_ok;
          if (state_nxt == brbm_pkg::ST_IDLE) begin
            out_valid_nxt = 1'b1;
            out_result_nxt.rd_word = '0;
            out_result_nxt.done_kind = in_cmd.kind;
          end
        end
      end
      brbm_pkg::ST_ACT: begin
        cnt_nxt      = cnt_r + 1'b1;
        rd_valid_nxt = copy_issue;
        rb_we        = rd_valid_r;
        rb_waddr     = {bank_r, wcol_r};
        rb_wdata     = cell_rdata;
        if (copy_last) begin
          out_valid_nxt = 1'b1;
          out_result_nxt.rd_word = '0;
          out_result_nxt.done_kind = brbm_pkg::KIND_ACTIVATE;
        end
      end
      brbm_pkg::ST_PRE: begin
        cnt_nxt      = cnt_r + 1'b1;
        rd_valid_nxt = copy_issue;
        cell_we      = rd_valid_r;
        cell_waddr   = {bank_r, open_row_r[bank_r], wcol_r};
        cell_wdata   = rb_rdata;
        if (copy_last) begin
          out_valid_nxt = 1'b1;
          out_result_nxt.rd_word = '0;
          out_result_nxt.done_kind = brbm_pkg::KIND_PRECHARGE;
        end
      end
      brbm_pkg::ST_READ: begin
        out_valid_nxt = 1'b1;
        out_result_nxt.rd_word = brbm_pkg::from_word(rb_rdata);
        out_result_nxt.done_kind = brbm_pkg::KIND_READ;
      end
      default: begin
        clr_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= brbm_pkg::ST_CLEAR;
      clr_r       <= '0;
      cnt_r       <= '0;
      rd_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < brbm_pkg::BANKS; i++) begin
        open_row_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      cnt_r       <= cnt_nxt;
      rd_valid_r  <= rd_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (do_open) begin
        open_row_r[brbm_pkg::bank_idx(in_cmd.bank)] <= brbm_pkg::row_idx(in_cmd.row);
      end
    end
  end

  always_ff @(posedge clk) begin
    out_result_r <= out_result_nxt;
    wcol_r       <= cnt_r[brbm_pkg::COL_W-1:0];
    if (accept) begin
      bank_r <= brbm_pkg::bank_idx(in_cmd.bank);
      row_r  <= brbm_pkg::row_idx(in_cmd.row);
    end
  end

  assign out_valid  = out_valid_r;
  assign out_result = out_result_r;

endmodule

### sv/brbm_checker.sv
// ----------------------------------------------------------------------------
// brbm_checker
// Port-level checks on command and result timing of the banked row buffer
// memory, bound to the top level.
// ----------------------------------------------------------------------------
module brbm_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input brbm_pkg::cmd_t    in_cmd,
  input logic              out_valid,
  input brbm_pkg::result_t out_result
);

  logic accept, read_ok;

  assign accept  = start && !busy;
  assign read_ok = (in_cmd.kind == brbm_pkg::KIND_READ)
                && (32'(in_cmd.bank) < brbm_pkg::BANKS)
                && (32'(in_cmd.column) < brbm_pkg::COLUMNS);

  a_write_next: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_cmd.kind == brbm_pkg::KIND_WRITE) |=>
      out_valid && (out_result.done_kind == brbm_pkg::KIND_WRITE))
    else $error("write transaction did not complete in the next cycle");

  a_read_latency: assert property (@(posedge clk) disable iff (!rst_n)
    accept && read_ok |=> !out_valid ##1
      (out_valid && (out_result.done_kind == brbm_pkg::KIND_READ)))
    else $error("read result not two cycles after the transaction");

  a_accept_follow: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy || out_valid)
    else $error("accepted transaction neither busy nor completed");

  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while busy");

  a_zero_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_result.done_kind != brbm_pkg::KIND_READ) |->
      (out_result.rd_word == 16'h0000))
    else $error("nonzero read data on a non-read result");

endmodule

bind banked_row_buffer_memory brbm_checker u_brbm_checker (.*);
